// File: rtl/clipmap_ring_strip_index_gen_assert.svh
// Assertion macros shared by the clipmap strip index generator checkers.
// Clocked on the rising edge of clock and disabled while reset is high.
`ifndef CLIPMAP_RING_STRIP_INDEX_GEN_ASSERT_SVH
`define CLIPMAP_RING_STRIP_INDEX_GEN_ASSERT_SVH

// Antecedent true implies consequent in the same cycle.
`define CRSIG_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("clipmap strip index check failed");

// Antecedent true implies consequent in the next cycle.
`define CRSIG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("clipmap strip index check failed");

`endif

// File: rtl/crsig_pkg.sv
// Shared types and constants for the clipmap ring strip index generator.
// No dependencies; used by crsig_walk and the top level.
`default_nettype none

package crsig_pkg;

   // Field and state widths.
   localparam int GLOG_W = 4;
   localparam int VERT_W = 21;
   localparam int LAP_W  = 8;
   localparam int M_W    = 9;
   localparam int RUN_W  = 10;
   localparam int STEP_W = 11;
   localparam int N_W    = 11;

   // Grid size limits and the size after reset.
   localparam logic [GLOG_W-1:0] MIN_GRID_LOG   = 4'd2;
   localparam logic [GLOG_W-1:0] MAX_GRID_LOG   = 4'd10;
   localparam logic [GLOG_W-1:0] RESET_GRID_LOG = 4'd8;

   // Stream widths.
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   // One generated index.
   typedef struct packed {
      logic [VERT_W-1:0] vertex_index;
      logic              last_index;
   } crsig_result_type;

endpackage

`default_nettype wire

// File: rtl/clipmap_ring_strip_index_gen.sv
// Each result is registered into the output register, or into the skid register while
// rsp_ is stalled. Throughput: one index per clock while req_tready is high; a two-entry
// output buffer (result register plus skid register) keeps req_tready high
// while one result waits on a stalled rsp_ side.
// Reset (synchronous, active high) empties the buffer, sets grid_log to 8 and
// puts the walker at the start of a sequence.
`default_nettype none

module clipmap_ring_strip_index_gen
   import crsig_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Configuration: grid_log.
   input  wire logic                  csr_wen,
   input  wire logic [GLOG_W-1:0]     csr_wdata,
   // Request stream.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [0] restart_seq, [7:1] zero
   // Result stream.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // [20:0] vertex_index, [23:21] zero
   output logic                       rsp_tlast   // last_index
);

   logic [GLOG_W-1:0] grid_log_ff;
   logic              accept;
   logic              pop;
   crsig_result_type  step_res;
   crsig_result_type  out_ff;
   crsig_result_type  skid_ff;
   logic              out_valid_ff;
   logic              skid_valid_ff;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;

   // Grid size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_log_ff <= RESET_GRID_LOG;
      end else if (csr_wen) begin
         grid_log_ff <= csr_wdata;
      end
   end

   crsig_walk u_walk (
      .clock    (clock),
      .reset    (reset),
      .step_en  (accept),
      .restart  (req_tdata[0]),
      .grid_log (grid_log_ff),
      .result   (step_res)
   );

   // Output register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_ff       <= step_res;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= step_res;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - VERT_W){1'b0}}, out_ff.vertex_index};
   assign rsp_tlast  = out_ff.last_index;

endmodule

`default_nettype wire

// File: rtl/crsig_walk.sv
// Spiral walker: holds the strip walk state and produces one index per step.
// Depends on crsig_pkg.
`default_nettype none

module crsig_walk
   import crsig_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step_en,
   input  wire logic                restart,
   input  wire logic [GLOG_W-1:0]   grid_log,
   output crsig_result_type         result
);

   typedef enum logic [3:0] {
      PH_START0 = 4'd0,
      PH_START1 = 4'd1,
      PH_UPPER  = 4'd2,
      PH_C1     = 4'd3,
      PH_RIGHT  = 4'd4,
      PH_C2     = 4'd5,
      PH_BOTTOM = 4'd6,
      PH_C3     = 4'd7,
      PH_LEFT   = 4'd8,
      PH_C4     = 4'd9
   } phase_type;

   // Start position for the grid size after reset (n = 256, m = 64).
   localparam int RST_N = 1 << RESET_GRID_LOG;
   localparam int RST_M = RST_N / 4;
   localparam logic [VERT_W-1:0] RST_INNER = VERT_W'((RST_N + 1) * RST_M + RST_M);
   localparam logic [VERT_W-1:0] RST_OUTER = VERT_W'((RST_N + 1) * RST_M + RST_M - (RST_N + 1));
   localparam logic [RUN_W-1:0]  RST_RUN   = RUN_W'(2 * RST_M);

   logic [VERT_W-1:0] inner_ff, inner_in;
   logic [VERT_W-1:0] outer_ff, outer_in;
   logic [LAP_W-1:0]  lap_ff, lap_in;
   logic [RUN_W-1:0]  run_len_ff, run_len_in;
   logic [STEP_W-1:0] run_step_ff, run_step_in;
   phase_type         phase_ff, phase_in;
   logic              half_ff, half_in;

   logic [GLOG_W-1:0] g_eff;
   logic [N_W-1:0]    n_val;
   logic [M_W-1:0]    m_val;
   logic [VERT_W-1:0] off_val;
   logic [4:0]        sq_shamt;
   logic [VERT_W-1:0] start_inner;
   logic [STEP_W-1:0] run_count;
   logic [STEP_W-1:0] step_inc;
   logic              run_done;
   logic              lap_last;
   phase_type         phase_cur;
   logic [VERT_W-1:0] vert;
   logic              last;

   // Clamp the live grid size and derive n, m, the row pitch and the start vertex.
   always_comb begin
      g_eff = grid_log;
      if (grid_log < MIN_GRID_LOG) begin
         g_eff = MIN_GRID_LOG;
      end else if (grid_log > MAX_GRID_LOG) begin
         g_eff = MAX_GRID_LOG;
      end
      n_val    = N_W'(1) << g_eff;
      m_val    = M_W'(n_val >> 2);
      off_val  = VERT_W'(n_val) + VERT_W'(1);
      // (n+1)*m + m equals n*m + 2m, and n*m is a power of two.
      sq_shamt = {g_eff, 1'b0} - 5'd2;
      start_inner = (VERT_W'(1) << sq_shamt) + (VERT_W'(m_val) << 1);
   end

   // Run length per side: upper L, right and bottom L+1, left L+2.
   always_comb begin
      case (phase_cur)
         PH_RIGHT, PH_BOTTOM: run_count = STEP_W'(run_len_ff) + STEP_W'(1);
         PH_LEFT:             run_count = STEP_W'(run_len_ff) + STEP_W'(2);
         default:             run_count = STEP_W'(run_len_ff);
      endcase
      step_inc = run_step_ff + STEP_W'(1);
      run_done = (step_inc >= run_count);
      lap_last = ({1'b0, lap_ff} + M_W'(1)) >= m_val;
   end

   // One step of the spiral walk.
   always_comb begin
      phase_cur   = restart ? PH_START0 : phase_ff;
      inner_in    = inner_ff;
      outer_in    = outer_ff;
      lap_in      = lap_ff;
      run_len_in  = run_len_ff;
      run_step_in = run_step_ff;
      phase_in    = phase_cur;
      half_in     = half_ff;
      vert        = '0;
      last        = 1'b0;

      unique case (phase_cur)
         PH_START1: begin
            vert        = outer_ff;
            outer_in    = outer_ff + VERT_W'(1);
            inner_in    = inner_ff + VERT_W'(1);
            run_step_in = '0;
            half_in     = 1'b0;
            phase_in    = PH_UPPER;
         end
         PH_UPPER: begin
            if (!half_ff) begin
               vert    = inner_ff;
               half_in = 1'b1;
            end else begin
               vert        = outer_ff;
               outer_in    = outer_ff + VERT_W'(1);
               inner_in    = inner_ff + VERT_W'(1);
               half_in     = 1'b0;
               run_step_in = run_done ? '0 : step_inc;
               if (run_done) begin
                  phase_in = PH_C1;
               end
            end
         end
         PH_C1: begin
            vert     = outer_ff;
            outer_in = outer_ff + off_val;
            inner_in = inner_ff - VERT_W'(1);
            phase_in = PH_RIGHT;
         end
         PH_RIGHT: begin
            if (!half_ff) begin
               vert    = outer_ff;
               half_in = 1'b1;
            end else begin
               vert        = inner_ff;
               outer_in    = outer_ff + off_val;
               inner_in    = inner_ff + off_val;
               half_in     = 1'b0;
               run_step_in = run_done ? '0 : step_inc;
               if (run_done) begin
                  phase_in = PH_C2;
               end
            end
         end
         PH_C2: begin
            vert     = outer_ff;
            outer_in = outer_ff - VERT_W'(1);
            inner_in = inner_ff - off_val;
            phase_in = PH_BOTTOM;
         end
         PH_BOTTOM: begin
            if (!half_ff) begin
               vert    = inner_ff;
               half_in = 1'b1;
            end else begin
               vert        = outer_ff;
               outer_in    = outer_ff - VERT_W'(1);
               inner_in    = inner_ff - VERT_W'(1);
               half_in     = 1'b0;
               run_step_in = run_done ? '0 : step_inc;
               if (run_done) begin
                  phase_in = PH_C3;
               end
            end
         end
         PH_C3: begin
            vert     = outer_ff;
            outer_in = outer_ff - off_val;
            inner_in = inner_ff + VERT_W'(1);
            phase_in = PH_LEFT;
         end
         PH_LEFT: begin
            if (!half_ff) begin
               vert    = outer_ff;
               half_in = 1'b1;
            end else begin
               vert        = inner_ff;
               outer_in    = outer_ff - off_val;
               inner_in    = inner_ff - off_val;
               half_in     = 1'b0;
               run_step_in = run_done ? '0 : step_inc;
               if (run_done) begin
                  // The final lap has no closing corner.
                  if (lap_last) begin
                     last     = 1'b1;
                     phase_in = PH_START0;
                  end else begin
                     phase_in = PH_C4;
                  end
               end
            end
         end
         PH_C4: begin
            vert       = outer_ff;
            outer_in   = outer_ff + VERT_W'(1);
            inner_in   = inner_ff + off_val;
            run_len_in = run_len_ff + RUN_W'(2);
            lap_in     = lap_ff + LAP_W'(1);
            phase_in   = PH_UPPER;
         end
         default: begin
            // Start of a sequence: load the size that is current now.
            inner_in    = start_inner;
            outer_in    = start_inner - off_val;
            lap_in      = '0;
            run_len_in  = RUN_W'({m_val, 1'b0});
            run_step_in = '0;
            half_in     = 1'b0;
            vert        = start_inner;
            phase_in    = PH_START1;
         end
      endcase
   end

   assign result.vertex_index = vert;
   assign result.last_index   = last;

   // Walk state advances once per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff    <= RST_INNER;
         outer_ff    <= RST_OUTER;
         lap_ff      <= '0;
         run_len_ff  <= RST_RUN;
         run_step_ff <= '0;
         phase_ff    <= PH_START0;
         half_ff     <= 1'b0;
      end else if (step_en) begin
         inner_ff    <= inner_in;
         outer_ff    <= outer_in;
         lap_ff      <= lap_in;
         run_len_ff  <= run_len_in;
         run_step_ff <= run_step_in;
         phase_ff    <= phase_in;
         half_ff     <= half_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/crsig_checker.sv
// Port-level checks for the clipmap strip index generator, bound to the top level.
// Depends on crsig_pkg and clipmap_ring_strip_index_gen_assert.svh.
`default_nettype none

`include "clipmap_ring_strip_index_gen_assert.svh"

module crsig_checker
   import crsig_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast
);

   // A stalled result word holds its contents.
   `CRSIG_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
                      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // With no result pending the buffer has room, so requests are taken.
   `CRSIG_ASSERT_SAME(a_ready_when_empty, !rsp_tvalid, req_tready)

   // Every accepted request leaves a result word visible next cycle.
   `CRSIG_ASSERT_NEXT(a_accept_gives_word, req_tvalid && req_tready, rsp_tvalid)

   // The buffer comes out of reset empty.
   `CRSIG_ASSERT_SAME(a_empty_after_reset, $past(reset), !rsp_tvalid)

endmodule

bind clipmap_ring_strip_index_gen crsig_checker u_crsig_checker (.*);

`default_nettype wire

// File: tb/sv/clipmap_ring_strip_index_gen_tb.sv
// Self-checking testbench for clipmap_ring_strip_index_gen: streams restart and next requests,
// predicts every vertex index and last flag, and checks each result word in order.
// Depends on crsig_pkg and the clipmap_ring_strip_index_gen RTL only.
module clipmap_ring_strip_index_gen_tb
   import crsig_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any accepted word before the run is declared hung.
   localparam int STUCK_LIMIT = 5000;

   // Walk positions of the strip generator.
   typedef enum logic [3:0] {
      WALK_START0 = 4'd0,
      WALK_START1 = 4'd1,
      WALK_UPPER  = 4'd2,
      WALK_C1     = 4'd3,
      WALK_RIGHT  = 4'd4,
      WALK_C2     = 4'd5,
      WALK_BOTTOM = 4'd6,
      WALK_C3     = 4'd7,
      WALK_LEFT   = 4'd8,
      WALK_C4     = 4'd9
   } walk_phase_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wen = 1'b0;
   logic [GLOG_W-1:0]     csr_wdata = RESET_GRID_LOG;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // Requests waiting to be sent and indices waiting to come back.
   logic             restart_queue[$];
   crsig_result_type pending_indices[$];

   // Idle behavior of both sides, set per phase.
   int send_idle_pct = 0;
   int stall_pct = 0;
   int stall_burst_len = 0;
   int fail_count = 0;
   int stuck_cycles = 0;

   // Shadow of the grid size register and of the walker state.
   logic [GLOG_W-1:0] grid_log_copy = RESET_GRID_LOG;
   logic [VERT_W-1:0] inner_vtx = '0;
   logic [VERT_W-1:0] outer_vtx = '0;
   logic [LAP_W-1:0]  lap_cnt = '0;
   logic [RUN_W-1:0]  run_len = '0;
   logic [STEP_W-1:0] run_pos = '0;
   logic              half_sel = 1'b0;
   walk_phase_type    walk_pos = WALK_START0;

   clipmap_ring_strip_index_gen dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5ns clock = ~clock;

   // Step to the next pair of a run; true once the run has all its pairs.
   function automatic logic close_pair(input int pair_count);
      run_pos  = run_pos + 1'b1;
      half_sel = 1'b0;
      if (run_pos >= pair_count) begin
         run_pos = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advance the shadow walker by one word and return the index it emits.
   function automatic crsig_result_type next_strip_index(input logic restart_seq);
      int unsigned       eff_log;
      logic [N_W-1:0]    side;
      logic [M_W-1:0]    quarter;
      logic [VERT_W-1:0] row_step;
      crsig_result_type  res;
      eff_log = grid_log_copy;
      if (eff_log < MIN_GRID_LOG) eff_log = MIN_GRID_LOG;
      if (eff_log > MAX_GRID_LOG) eff_log = MAX_GRID_LOG;
      side     = N_W'(1) << eff_log;
      quarter  = M_W'(side >> 2);
      row_step = VERT_W'(side) + 1'b1;
      res.vertex_index = '0;
      res.last_index   = 1'b0;
      if (restart_seq) walk_pos = WALK_START0;

      case (walk_pos)
         WALK_START1: begin
            res.vertex_index = outer_vtx;
            outer_vtx = outer_vtx + 1'b1;
            inner_vtx = inner_vtx + 1'b1;
            run_pos   = '0;
            half_sel  = 1'b0;
            walk_pos  = WALK_UPPER;
         end
         WALK_UPPER: begin
            if (!half_sel) begin
               res.vertex_index = inner_vtx;
               half_sel = 1'b1;
            end else begin
               res.vertex_index = outer_vtx;
               outer_vtx = outer_vtx + 1'b1;
               inner_vtx = inner_vtx + 1'b1;
               if (close_pair(int'(run_len))) walk_pos = WALK_C1;
            end
         end
         WALK_C1: begin
            res.vertex_index = outer_vtx;
            outer_vtx = outer_vtx + row_step;
            inner_vtx = inner_vtx - 1'b1;
            walk_pos  = WALK_RIGHT;
         end
         WALK_RIGHT: begin
            if (!half_sel) begin
               res.vertex_index = outer_vtx;
               half_sel = 1'b1;
            end else begin
               res.vertex_index = inner_vtx;
               outer_vtx = outer_vtx + row_step;
               inner_vtx = inner_vtx + row_step;
               if (close_pair(int'(run_len) + 1)) walk_pos = WALK_C2;
            end
         end
         WALK_C2: begin
            res.vertex_index = outer_vtx;
            outer_vtx = outer_vtx - 1'b1;
            inner_vtx = inner_vtx - row_step;
            walk_pos  = WALK_BOTTOM;
         end
         WALK_BOTTOM: begin
            if (!half_sel) begin
               res.vertex_index = inner_vtx;
               half_sel = 1'b1;
            end else begin
               res.vertex_index = outer_vtx;
               outer_vtx = outer_vtx - 1'b1;
               inner_vtx = inner_vtx - 1'b1;
               if (close_pair(int'(run_len) + 1)) walk_pos = WALK_C3;
            end
         end
         WALK_C3: begin
            res.vertex_index = outer_vtx;
            outer_vtx = outer_vtx - row_step;
            inner_vtx = inner_vtx + 1'b1;
            walk_pos  = WALK_LEFT;
         end
         WALK_LEFT: begin
            if (!half_sel) begin
               res.vertex_index = outer_vtx;
               half_sel = 1'b1;
            end else begin
               res.vertex_index = inner_vtx;
               outer_vtx = outer_vtx - row_step;
               inner_vtx = inner_vtx - row_step;
               if (close_pair(int'(run_len) + 2)) begin
                  // The outermost lap ends the strip without a closing corner.
                  if (int'(lap_cnt) + 1 >= int'(quarter)) begin
                     res.last_index = 1'b1;
                     walk_pos = WALK_START0;
                  end else begin
                     walk_pos = WALK_C4;
                  end
               end
            end
         end
         WALK_C4: begin
            res.vertex_index = outer_vtx;
            outer_vtx = outer_vtx + 1'b1;
            inner_vtx = inner_vtx + row_step;
            run_len   = run_len + 2'd2;
            lap_cnt   = lap_cnt + 1'b1;
            walk_pos  = WALK_UPPER;
         end
         default: begin
            // Start of a strip: the size is taken from the register right now.
            inner_vtx = row_step * quarter + quarter;
            outer_vtx = inner_vtx - row_step;
            lap_cnt   = '0;
            run_len   = RUN_W'(2 * quarter);
            run_pos   = '0;
            half_sel  = 1'b0;
            res.vertex_index = inner_vtx;
            walk_pos  = WALK_START1;
         end
      endcase
      return res;
   endfunction

   // Request driver: offers queued words, idling at random, and predicts on acceptance.
   always @(posedge clock) begin
      crsig_result_type predicted;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted       = next_strip_index(req_tdata[0]);
            pending_indices = {pending_indices, predicted};
         end
         if (!req_tvalid || req_tready) begin
            if (restart_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, restart_queue.pop_front()};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each accepted word and drives the stalling of rsp_tready.
   always @(posedge clock) begin
      crsig_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_indices.size() == 0) begin
               $error("unexpected result word: vertex_index %0d, last_index %0b",
                      rsp_tdata[VERT_W-1:0], rsp_tlast);
               fail_count++;
            end else begin
               want = pending_indices.pop_front();
               if (rsp_tdata[VERT_W-1:0] !== want.vertex_index) begin
                  $error("vertex_index: expected %0d, got %0d",
                         want.vertex_index, rsp_tdata[VERT_W-1:0]);
                  fail_count++;
               end
               if (rsp_tlast !== want.last_index) begin
                  $error("last_index: expected %0b, got %0b", want.last_index, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tdata[RSP_DATA_W-1:VERT_W] !== '0) begin
                  $error("tdata padding: expected 0, got %0h", rsp_tdata[RSP_DATA_W-1:VERT_W]);
                  fail_count++;
               end
            end
         end
         // A long hold-off takes priority over the random stalls.
         if (stall_burst_len > 0) begin
            rsp_tready <= 1'b0;
            stall_burst_len = stall_burst_len - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Watchdog on cycles in which no word moves on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("clipmap_ring_strip_index_gen regression: fail");
         $finish;
      end
   end

   // Wait until every request is sent and every index has come back.
   task automatic wait_for_drain();
      do @(negedge clock);
      while (restart_queue.size() != 0 || req_tvalid || pending_indices.size() != 0);
   endtask

   // Write the grid size register while the block is idle.
   task automatic write_grid_log(input logic [GLOG_W-1:0] glog);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= glog;
      @(posedge clock);
      csr_wen <= 1'b0;
      grid_log_copy = glog;
   endtask

   // Append one request word to the send queue.
   task automatic queue_request(input logic restart_seq);
      restart_queue = {restart_queue, restart_seq};
   endtask

   // One random phase: new grid size, idle mix, mostly next requests with some restarts.
   task automatic run_phase(input logic [GLOG_W-1:0] glog, input int word_count,
                            input int send_pct, input int stall_in, input int restart_pm,
                            input int hold_cycles);
      logic rb;
      wait_for_drain();
      write_grid_log(glog);
      @(negedge clock);
      send_idle_pct = send_pct;
      stall_pct     = stall_in;
      for (int k = 0; k < word_count; k++) begin
         // The first word either restarts or carries the walk over into the new size.
         if (k == 0) rb = $urandom_range(1);
         else rb = ($urandom_range(999) < restart_pm);
         queue_request(rb);
      end
      if (hold_cycles > 0) stall_burst_len = hold_cycles;
   endtask

   // Stimulus sequence and final verdict.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset size: the first words of a 256-cell strip.
      @(negedge clock);
      repeat (4) queue_request(1'b0);
      wait_for_drain();

      // Smallest grid through a register value below range: one full strip and the wrap.
      write_grid_log(4'd0);
      @(negedge clock);
      queue_request(1'b1);
      repeat (29) queue_request(1'b0);

      run_phase(4'd3,  250, 0,  0,  5,   0);
      run_phase(4'd2,  200, 66, 0,  20,  0);
      run_phase(4'd15, 150, 0,  66, 3,   0);
      run_phase(4'd4,  420, 10, 10, 2,   0);
      run_phase(4'd1,  120, 0,  0,  125, 0);
      run_phase(4'd10, 150, 66, 0,  10,  0);
      // Receiver holds off for a long stretch while requests keep coming.
      run_phase(4'd5,  160, 0,  0,  0,   64);
      run_phase(4'd8,  100, 10, 10, 50,  0);
      run_phase(4'd3,  150, 0,  0,  5,   0);

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_indices.size() == 0) begin
         $display("clipmap_ring_strip_index_gen regression: pass");
      end else begin
         $display("clipmap_ring_strip_index_gen regression: fail");
      end
      $finish;
   end

endmodule
